// File: rtl/core/pcmf_pkg.sv
package pcmf_pkg;

  localparam int COEF_WIDTH_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 12;

  localparam int NUM_CH    = 4;   // R, G, B, A lanes
  localparam int DEN_W     = 9;   // divisor: 2*alpha, or 1 on the alpha lane
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_WEIGHTS   = 3'd0,
    CFG_GREEN_WEIGHTS = 3'd1,
    CFG_BLUE_WEIGHTS  = 3'd2,
    CFG_ALPHA_WEIGHTS = 3'd3,
    CFG_OFFSETS       = 3'd4
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RED_WEIGHTS_RST   = 64'd4096;
  localparam logic [CFG_W-1:0] GREEN_WEIGHTS_RST = 64'd268435456;
  localparam logic [CFG_W-1:0] BLUE_WEIGHTS_RST  = 64'd17592186044416;
  localparam logic [CFG_W-1:0] ALPHA_WEIGHTS_RST = 64'd1152921504606846976;
  localparam logic [CFG_W-1:0] OFFSETS_RST       = 64'd0;

endpackage

// File: rtl/core/premultiplied_color_matrix_filter.sv
// Throughput: one pixel per clock; busy is never raised. The receiver cannot stall.
// The depth is set by the divider (one quotient bit per stage) plus five
// matrix/clamp/premultiply stages.
// Reset (synchronous, rst_n low): pipeline empty, registers at identity matrix, zero offsets.
module premultiplied_color_matrix_filter #(
  parameter int COEF_WIDTH     = pcmf_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = pcmf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       in_alpha,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  output logic                             out_valid,
  output logic [7:0]                       out_alpha,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  input  logic                             cfg_we,
  input  logic [pcmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcmf_pkg::CFG_W-1:0]       cfg_data
);
  import pcmf_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int F    = COEF_FRAC_BITS;
  localparam int QW   = F + 1;               // unpremultiplied value, 0 .. 1.0
  localparam int NW   = QW + 8;              // dividend width
  localparam int PADW = (4 * W > CFG_W) ? 4 * W : CFG_W;
  localparam int PW   = W + QW + 1;          // one weight x value product
  localparam int ACCW = PW + 3;              // four products plus offset
  localparam int CMPW = (ACCW > 2 * F + 2) ? ACCW : 2 * F + 2;
  localparam int XPW  = 2 * QW;              // xf * af

  localparam logic [CMPW-1:0]  ONE2   = CMPW'(1) << (2 * F);
  localparam logic [2*F+1:0]   HALF_F = (2 * F + 2)'(1) << (F - 1);
  localparam logic [F+8:0]     HALF_A = (F + 9)'(1) << (F - 1);
  localparam logic [XPW+8:0]   HALF_X = (XPW + 9)'(1) << (2 * F - 1);

  // no back-pressure: every start is taken
  assign busy = 1'b0;

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] wgt_r [NUM_CH];   // rows: out R, G, B, A
  logic [CFG_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_r[0] <= RED_WEIGHTS_RST;
      wgt_r[1] <= GREEN_WEIGHTS_RST;
      wgt_r[2] <= BLUE_WEIGHTS_RST;
      wgt_r[3] <= ALPHA_WEIGHTS_RST;
      off_r    <= OFFSETS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RED_WEIGHTS:   wgt_r[0] <= cfg_data;
        CFG_GREEN_WEIGHTS: wgt_r[1] <= cfg_data;
        CFG_BLUE_WEIGHTS:  wgt_r[2] <= cfg_data;
        CFG_ALPHA_WEIGHTS: wgt_r[3] <= cfg_data;
        CFG_OFFSETS:       off_r    <= cfg_data;
        default: ;         // unknown index: ignored
      endcase
    end
  end

  // Unpack the s.F fields; bits past 63 read as zero (only for W > 16).
  logic signed [W-1:0] wf  [NUM_CH][NUM_CH];
  logic signed [W-1:0] off [NUM_CH];

  always_comb begin
    logic [PADW-1:0] pad;
    for (int r = 0; r < NUM_CH; r++) begin
      pad = PADW'(wgt_r[r]);
      for (int c = 0; c < NUM_CH; c++) begin
        wf[r][c] = pad[c*W +: W];
      end
    end
    pad = PADW'(off_r);
    for (int c = 0; c < NUM_CH; c++) begin
      off[c] = pad[c*W +: W];
    end
  end

  // ---------------- unpremultiply: divider ----------------
  // colour lane: round(min(c,a) * 2^F / a) = floor((2c*2^F + a) / 2a)
  // alpha lane:  round(a * 2^F / 255) from a constant table, passed through
  //              the divider with divisor 1 to stay aligned with the colours
  // Zero alpha gives dividend 0 on colour lanes; divisor forced to 1.
  logic [NUM_CH-1:0][NW-1:0]    div_num;
  logic [NUM_CH-1:0][DEN_W-1:0] div_den;
  logic [7:0]                   in_col [3];
  logic [QW-1:0]                alpha_lut [256];
  logic                         div_valid;
  logic [NUM_CH-1:0][QW-1:0]    vec;

  assign in_col[0] = in_red;
  assign in_col[1] = in_green;
  assign in_col[2] = in_blue;

  genvar g;
  generate
    for (g = 0; g < 256; g++) begin : g_alut
      assign alpha_lut[g] = QW'((2 * g * (2 ** F) + 255) / 510);
    end
  endgenerate

  always_comb begin
    logic [7:0] c;
    for (int i = 0; i < 3; i++) begin
      c = (in_col[i] > in_alpha) ? in_alpha : in_col[i];
      div_num[i] = {c, QW'(in_alpha)};
      div_den[i] = (in_alpha == 8'd0) ? DEN_W'(1) : {in_alpha, 1'b0};
    end
    div_num[3] = NW'(alpha_lut[in_alpha]);
    div_den[3] = DEN_W'(1);
  end

  pcmf_div #(
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_num    (div_num),
    .in_den    (div_den),
    .out_valid (div_valid),
    .out_quo   (vec)
  );

  // ---------------- M1: sixteen products ----------------
  logic signed [PW-1:0] prod_r [NUM_CH][NUM_CH];
  logic                 m1_v_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_CH; r++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        prod_r[r][c] <= wf[r][c] * $signed({1'b0, vec[c]});
      end
    end
  end

  // ---------------- M2: row sums plus offset ----------------
  logic signed [ACCW-1:0] acc_r [NUM_CH];
  logic                   m2_v_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_CH; r++) begin
      acc_r[r] <= ACCW'(prod_r[r][0]) + ACCW'(prod_r[r][1]) + ACCW'(prod_r[r][2])
                + ACCW'(prod_r[r][3]) + ACCW'($signed({off[r], {F{1'b0}}}));
    end
  end

  // ---------------- M3: clamp to 0..1, round to F bits ----------------
  logic [QW-1:0] cf_r [NUM_CH];     // index 3 is alpha
  logic          m3_zero_r;
  logic          m3_v_r;

  always_ff @(posedge clk) begin
    logic [CMPW-1:0]  x;
    logic [2*F+1:0]   cl;
    for (int r = 0; r < NUM_CH; r++) begin
      x = CMPW'($unsigned(acc_r[r]));
      if (acc_r[r][ACCW-1]) begin
        cl = '0;
      end else if (x > ONE2) begin
        cl = ONE2[2*F+1:0];
      end else begin
        cl = x[2*F+1:0];
      end
      cl = cl + HALF_F;
      cf_r[r] <= cl[2*F:F];
    end
    m3_zero_r <= acc_r[3][ACCW-1] || (acc_r[3] == '0);
  end

  // ---------------- M4: alpha byte, colour x alpha ----------------
  logic [7:0]     m4_alpha_r;
  logic [XPW-1:0] xa_r [3];
  logic           m4_zero_r;
  logic           m4_v_r;

  always_ff @(posedge clk) begin
    logic [F+8:0] a255;
    a255 = ((F + 9)'(cf_r[3]) << 8) - (F + 9)'(cf_r[3]) + HALF_A;
    m4_alpha_r <= a255[F+7:F];
    for (int i = 0; i < 3; i++) begin
      xa_r[i] <= XPW'(cf_r[i]) * XPW'(cf_r[3]);
    end
    m4_zero_r <= m3_zero_r;
  end

  // ---------------- M5: scale by 255, round, output register ----------------
  logic       out_valid_r;
  logic [7:0] out_alpha_r, out_red_r, out_green_r, out_blue_r;
  logic [7:0] col_byte [3];

  always_comb begin
    logic [XPW+8:0] p;
    for (int i = 0; i < 3; i++) begin
      p = ((XPW + 9)'(xa_r[i]) << 8) - (XPW + 9)'(xa_r[i]) + HALF_X;
      col_byte[i] = p[2*F+7:2*F];
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r <= m4_zero_r ? 8'd0 : m4_alpha_r;
    out_red_r   <= m4_zero_r ? 8'd0 : col_byte[0];
    out_green_r <= m4_zero_r ? 8'd0 : col_byte[1];
    out_blue_r  <= m4_zero_r ? 8'd0 : col_byte[2];
  end

  // valid bits for the matrix stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      m4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m1_v_r      <= div_valid;
      m2_v_r      <= m1_v_r;
      m3_v_r      <= m2_v_r;
      m4_v_r      <= m3_v_r;
      out_valid_r <= m4_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_alpha = out_alpha_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // ---------------- assertions ----------------
  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // premultiplied output: no colour byte exceeds alpha
  a_premul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= out_alpha) && (out_green <= out_alpha)
                  && (out_blue <= out_alpha))
    else $error("colour above alpha on output");

  // clamped alpha and red values never exceed 1.0
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    m4_v_r |-> $past(cf_r[3]) <= (QW'(1) << F) && $past(cf_r[0]) <= (QW'(1) << F))
    else $error("clamp out of range");

endmodule

// File: rtl/core/pcmf_div.sv
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Requires num < den * 2^QW so the top bits start below the divisor.
module pcmf_div #(
  parameter int QW = pcmf_pkg::COEF_FRAC_BITS_DEF + 1
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  input  logic [pcmf_pkg::NUM_CH-1:0][QW+7:0]            in_num,
  input  logic [pcmf_pkg::NUM_CH-1:0][pcmf_pkg::DEN_W-1:0] in_den,
  output logic                                           out_valid,
  output logic [pcmf_pkg::NUM_CH-1:0][QW-1:0]            out_quo
);
  import pcmf_pkg::*;

  logic [NUM_CH-1:0][DEN_W-1:0] rem_r   [QW];
  logic [NUM_CH-1:0][DEN_W-1:0] rem_nxt [QW];
  logic [NUM_CH-1:0][DEN_W-1:0] den_r   [QW];
  logic [NUM_CH-1:0][QW-1:0]    nq_r    [QW];
  logic [NUM_CH-1:0][QW-1:0]    nq_nxt  [QW];
  logic [QW-1:0]                vld_r;

  logic [NUM_CH-1:0][DEN_W-1:0] rem_in  [QW];
  logic [NUM_CH-1:0][DEN_W-1:0] den_in  [QW];
  logic [NUM_CH-1:0][QW-1:0]    nq_in   [QW];
  logic [QW-1:0]                vld_in;

  genvar s, l;
  generate
    for (s = 0; s < QW; s++) begin : g_step
      if (s == 0) begin : g_first
        for (l = 0; l < NUM_CH; l++) begin : g_lane
          assign rem_in[0][l] = {1'b0, in_num[l][QW+7:QW]};
          assign nq_in[0][l]  = in_num[l][QW-1:0];
        end
        assign den_in[0] = in_den;
        assign vld_in[0] = in_valid;
      end else begin : g_next
        assign rem_in[s] = rem_r[s-1];
        assign nq_in[s]  = nq_r[s-1];
        assign den_in[s] = den_r[s-1];
        assign vld_in[s] = vld_r[s-1];
      end

      always_comb begin : c_step
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int k = 0; k < NUM_CH; k++) begin
          t    = {rem_in[s][k], nq_in[s][k][QW-1]};
          diff = t - {1'b0, den_in[s][k]};
          ge   = (t >= {1'b0, den_in[s][k]});
          rem_nxt[s][k] = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
          nq_nxt[s][k]  = {nq_in[s][k][QW-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= vld_in[s];
        end
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
        den_r[s] <= den_in[s];
      end
    end
  endgenerate

  assign out_valid = vld_r[QW-1];
  assign out_quo   = nq_r[QW-1];

endmodule

// File: test/tb_premultiplied_color_matrix_filter.sv
module tb_premultiplied_color_matrix_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmf_pkg::*;

  localparam int W    = COEF_WIDTH_DEF;
  localparam int F    = COEF_FRAC_BITS_DEF;
  // pipeline depth is F+6; leave some margin after the last beat
  localparam int DRAIN_CYCLES = F + 30;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [7:0]       in_alpha = '0, in_red = '0, in_green = '0, in_blue = '0;
  logic             out_valid;
  logic [7:0]       out_alpha, out_red, out_green, out_blue;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RED_WEIGHTS;
  logic [CFG_W-1:0] cfg_data = '0;

  premultiplied_color_matrix_filter dut (
    .clk, .rst_n, .start, .busy,
    .in_alpha, .in_red, .in_green, .in_blue,
    .out_valid, .out_alpha, .out_red, .out_green, .out_blue,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // testbench copy of the matrix registers
  logic [CFG_W-1:0] mat_regs [NUM_CH+1];
  pixel_t           expected_pixels [$];
  int               errors = 0;
  int               idle_pct = 0;

  // signed W-bit field k of a register
  function automatic longint coef_field(logic [CFG_W-1:0] reg_val, int k);
    logic [W-1:0] raw;
    raw = reg_val[k*W +: W];
    return longint'($signed(raw));
  endfunction

  // clamp to 0..1.0 (2F frac bits) and round half up to F frac bits
  function automatic longint clamp_round(longint x);
    longint top;
    top = longint'(1) << (2*F);
    if (x < 0) x = 0;
    if (x > top) x = top;
    return (x + (longint'(1) << (F-1))) >>> F;
  endfunction

  function automatic pixel_t filter_pixel(pixel_t p);
    longint vec [4];
    longint acc [4];
    longint c, af, xf;
    logic [7:0] ch [3];
    pixel_t res;
    ch[0] = p.r; ch[1] = p.g; ch[2] = p.b;
    for (int i = 0; i < 4; i++) vec[i] = 0;
    if (p.a != 0) begin
      for (int i = 0; i < 3; i++) begin
        c = ch[i];
        if (c > p.a) c = p.a;          // invalid premultiplied: saturate at 1.0
        vec[i] = (2*c*(longint'(1) << F) + p.a) / (2*longint'(p.a));
      end
      vec[3] = (2*longint'(p.a)*(longint'(1) << F) + 255) / 510;
    end
    for (int k = 0; k < 4; k++) begin
      acc[k] = coef_field(mat_regs[NUM_CH], k) * (longint'(1) << F);
      for (int i = 0; i < 4; i++) acc[k] += coef_field(mat_regs[k], i) * vec[i];
    end
    if (acc[3] <= 0) return '0;        // transparent result
    af = clamp_round(acc[3]);
    res.a = 8'((af*255 + (longint'(1) << (F-1))) >>> F);
    xf = clamp_round(acc[0]);
    res.r = 8'((xf*af*255 + (longint'(1) << (2*F-1))) >>> (2*F));
    xf = clamp_round(acc[1]);
    res.g = 8'((xf*af*255 + (longint'(1) << (2*F-1))) >>> (2*F));
    xf = clamp_round(acc[2]);
    res.b = 8'((xf*af*255 + (longint'(1) << (2*F-1))) >>> (2*F));
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // result checker: every strobe is one beat, compared against the oldest pixel
  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        exp_p = expected_pixels.pop_front();
        if (out_alpha !== exp_p.a) report_mismatch("alpha", exp_p.a, out_alpha);
        if (out_red   !== exp_p.r) report_mismatch("red",   exp_p.r, out_red);
        if (out_green !== exp_p.g) report_mismatch("green", exp_p.g, out_green);
        if (out_blue  !== exp_p.b) report_mismatch("blue",  exp_p.b, out_blue);
      end
    end
  end

  // one input beat; start stays high across back-to-back beats
  // each cycle is idle with probability idle_pct percent
  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_alpha <= p.a;
    in_red   <= p.r;
    in_green <= p.g;
    in_blue  <= p.b;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(filter_pixel(p));
    @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge with the pipe empty
  task automatic drain_pipe();
    start <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_OFFSETS) mat_regs[idx] = val;
    @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_weights(bit for_alpha);
    logic [CFG_W-1:0] v;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = '0;
      2: v = '1;
      3: v = {4{16'h7FFF}};
      4: v = {4{16'h8000}};
      default: begin
        for (int k = 0; k < 4; k++)
          v[k*W +: W] = W'($urandom_range(0, 2*4096 + 2048) - 4096);
        if (for_alpha) v[3*W +: W] = W'($urandom_range(2048, 8192));
      end
    endcase
    return v;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.a = 8'($urandom);
    p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
    case ($urandom_range(19))
      0: p.a = 8'd0;
      1, 2: ;                          // raw bytes, often invalid
      default: begin                   // well-formed premultiplied pixel
        p.r = 8'($urandom_range(0, p.a));
        p.g = 8'($urandom_range(0, p.a));
        p.b = 8'($urandom_range(0, p.a));
      end
    endcase
    return p;
  endfunction

  // corner pixels: zero alpha, opaque extremes, color above alpha, half-way rounding
  task automatic send_corner_pixels();
    send_pixel('{8'd0,   8'd0,   8'd0,   8'd0});
    send_pixel('{8'd0,   8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0,   8'd0,   8'd0});
    send_pixel('{8'd1,   8'd1,   8'd0,   8'd1});
    send_pixel('{8'd1,   8'd255, 8'd2,   8'd0});
    send_pixel('{8'd128, 8'd200, 8'd64,  8'd127});
    send_pixel('{8'd3,   8'd1,   8'd2,   8'd3});
    send_pixel('{8'd170, 8'd85,  8'd170, 8'd255});
    send_pixel('{8'd254, 8'd127, 8'd253, 8'd1});
  endtask

  task automatic test_identity();
    idle_pct = 0;
    send_corner_pixels();
    drain_pipe();
  endtask

  // negative result alpha, alpha overflow, offsets only on transparent input
  task automatic test_matrix_corners();
    write_reg(CFG_OFFSETS, {16'hF000, 16'h0800, 16'h0400, 16'h1000});
    send_corner_pixels();
    drain_pipe();
    write_reg(CFG_ALPHA_WEIGHTS, {16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    write_reg(CFG_RED_WEIGHTS,   {16'h8000, 16'h2000, 16'hF000, 16'h7FFF});
    write_reg(CFG_OFFSETS,       {16'h0000, 16'hF800, 16'h7FFF, 16'h8000});
    send_corner_pixels();
    drain_pipe();
    write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});   // unused index
    write_reg(CFG_GREEN_WEIGHTS, '1);
    write_reg(CFG_BLUE_WEIGHTS,  {16'h1000, 16'h1000, 16'h1000, 16'h1000});
    write_reg(CFG_OFFSETS,       {16'h0800, 16'h0000, 16'h0000, 16'h0000});
    send_corner_pixels();
    drain_pipe();
  endtask

  task automatic test_random_phase(int pct, int n_items);
    idle_pct = pct;
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_RED_WEIGHTS,   rand_weights(1'b0));
      write_reg(CFG_GREEN_WEIGHTS, rand_weights(1'b0));
      write_reg(CFG_BLUE_WEIGHTS,  rand_weights(1'b0));
      write_reg(CFG_ALPHA_WEIGHTS, rand_weights(1'b1));
      write_reg(CFG_OFFSETS,       ($urandom_range(2) == 0) ? {$urandom, $urandom}
                                   : CFG_W'({4{W'($urandom_range(0, 1024))}}));
      for (int i = 0; i < n_items / 4; i++) send_pixel(rand_pixel());
      drain_pipe();   // sender holds off until every result is back
    end
  endtask

  initial begin
    mat_regs[CFG_RED_WEIGHTS]   = RED_WEIGHTS_RST;
    mat_regs[CFG_GREEN_WEIGHTS] = GREEN_WEIGHTS_RST;
    mat_regs[CFG_BLUE_WEIGHTS]  = BLUE_WEIGHTS_RST;
    mat_regs[CFG_ALPHA_WEIGHTS] = ALPHA_WEIGHTS_RST;
    mat_regs[CFG_OFFSETS]       = OFFSETS_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_identity();
    test_matrix_corners();
    test_random_phase(11, 200);
    test_random_phase(70, 200);
    test_random_phase(0, 200);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
